@@ rtl/view_cone_sphere_cull_unit_assert.svh @@
// ---------------------------------------------------------------------------
// View cone sphere cull - assertion macros
// Shorthand for clocked implication checks with reset disable.
// ---------------------------------------------------------------------------
`ifndef VIEW_CONE_SPHERE_CULL_UNIT_ASSERT_SVH
`define VIEW_CONE_SPHERE_CULL_UNIT_ASSERT_SVH

// consequent checked in the same cycle
`define VCSC_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the next cycle
`define VCSC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/vcsc_pkg.sv @@
// ---------------------------------------------------------------------------
// vcsc_pkg
// Shared constants, widths, tables and codes of the view cone sphere cull.
// ---------------------------------------------------------------------------
`default_nettype none

package vcsc_pkg;

  localparam int MAX_OBJECTS  = 4096;
  localparam int IDX_W        = $clog2(MAX_OBJECTS);

  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_LEN     = 24;
  localparam int ANGLE_W      = 32;

  localparam logic [ANGLE_W-1:0] ATAN_TAB [ATAN_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465,  32'd10680861,  32'd5340245,   32'd2670163,  32'd1335087,
    32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
    32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  localparam logic [ANGLE_W-1:0] CORDIC_GAIN  = 32'd652032874;
  localparam logic [ANGLE_W-1:0] TURN_QUARTER = 32'h4000_0000;
  localparam logic [ANGLE_W-1:0] TURN_HALF    = 32'h8000_0000;

  localparam int POS_W    = 25;
  localparam int DIFF_W   = POS_W + 1;
  localparam int HDG_W    = 16;
  localparam int RAD_W    = 16;
  localparam int WORLD_W  = 8;
  localparam int FAR_W    = 24;
  localparam int FOV_W    = 16;
  localparam int TRIG_W   = 32;
  localparam int ROT_W    = 34;
  localparam int SQ_W     = 2 * DIFF_W;
  localparam int LIM_W    = FAR_W + 1;
  localparam int LIMSQ_W  = 2 * LIM_W;
  localparam int ROOT_W   = 30;
  localparam int SQIN_W   = 2 * ROOT_W;
  localparam int REM_W    = ROOT_W + 3;
  localparam int SQ_PER   = 2;
  localparam int SQ_STAGES = ROOT_W / SQ_PER;
  localparam int PROD_W   = DIFF_W + TRIG_W;
  localparam int DOT_W    = 60;
  localparam int VEC_W    = 62;
  localparam int Q_SHIFT  = 30;
  localparam int NEAR_UNITS    = 2;
  localparam int ALPHA_Y_SHIFT = 28;
  localparam int ALPHA_X_SHIFT = 24;
  localparam int FOV_SHIFT     = 15;
  localparam int LIM_CMP_W     = ANGLE_W + 2;

  localparam logic [HDG_W-1:0] HDG_QUARTER = 16'h4000;

  localparam int IN_TDATA_W  = 232;
  localparam int OUT_TDATA_W = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = FAR_W;

  localparam logic [FAR_W-1:0] FAR_RESET  = 24'd400000;
  localparam logic [FOV_W-1:0] FOVH_RESET = 16'd32768;
  localparam logic [FOV_W-1:0] FOVV_RESET = 16'd16384;

  typedef enum logic [2:0] {
    RSN_VISIBLE = 3'd0,
    RSN_WORLD   = 3'd1,
    RSN_FAR     = 3'd2,
    RSN_BEHIND  = 3'd3,
    RSN_HORIZ   = 3'd4,
    RSN_VERT    = 3'd5
  } reason_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FAR_RANGE = 2'd0,
    CFG_FOV_H     = 2'd1,
    CFG_FOV_V     = 2'd2
  } cfg_idx_e;

endpackage

`default_nettype wire

@@ rtl/view_cone_sphere_cull_unit.sv @@
// ---------------------------------------------------------------------------
// view_cone_sphere_cull_unit: sphere against camera view cone, one word in, one out
// The sin/cos CORDIC, the dot products and the atan2 CORDIC run in series.
// Throughput one word per cycle; the whole pipeline holds while the output stalls.
// Async active-low reset empties the pipeline and loads the default registers.
// ---------------------------------------------------------------------------
`default_nettype none

module view_cone_sphere_cull_unit import vcsc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // cam_x, cam_y, cam_z, cam_heading, cam_pitch, cam_world,
  // obj_x, obj_y, obj_z, obj_radius, obj_world, obj_index, zero pad
  input  logic [IN_TDATA_W-1:0] s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // visible, reject_reason, object_index_out
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int OFS_CAM_Y  = POS_W;
  localparam int OFS_CAM_Z  = OFS_CAM_Y + POS_W;
  localparam int OFS_HDG    = OFS_CAM_Z + POS_W;
  localparam int OFS_PITCH  = OFS_HDG + HDG_W;
  localparam int OFS_CWORLD = OFS_PITCH + HDG_W;
  localparam int OFS_OBJ_X  = OFS_CWORLD + WORLD_W;
  localparam int OFS_OBJ_Y  = OFS_OBJ_X + POS_W;
  localparam int OFS_OBJ_Z  = OFS_OBJ_Y + POS_W;
  localparam int OFS_RAD    = OFS_OBJ_Z + POS_W;
  localparam int OFS_OWORLD = OFS_RAD + RAD_W;
  localparam int OFS_IDX    = OFS_OWORLD + WORLD_W;

  // stage map
  localparam int ROT_K  = (SQ_STAGES > CORDIC_STEPS + 2) ? SQ_STAGES - CORDIC_STEPS - 2 : 0;
  localparam int T_K    = ROT_K + CORDIC_STEPS + 2;
  localparam int DIST_K = 3 + SQ_STAGES;
  localparam int FX_K   = T_K + 1;
  localparam int PR_K   = T_K + 2;
  localparam int DOT_K  = T_K + 3;
  localparam int NEAR_K = T_K + 4;
  localparam int DEPTH  = DOT_K + CORDIC_STEPS + 2;

  typedef struct packed {
    logic [IDX_W-1:0]         idx;
    logic [RAD_W-1:0]         r;
    logic                     wne;
    logic                     far;
    logic                     near;
    logic [HDG_W-1:0]         yaw;
    logic [HDG_W-1:0]         pitch;
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic signed [DIFF_W-1:0] dz;
    logic [SQ_W-1:0]          dxx;
    logic [SQ_W-1:0]          dyy;
    logic [SQ_W-1:0]          dzz;
    logic [SQ_W-1:0]          sumsq;
    logic [LIM_W-1:0]         lim;
    logic [LIMSQ_W-1:0]       limsq;
    logic [ROOT_W-1:0]        span;
    logic signed [TRIG_W-1:0] cy;
    logic signed [TRIG_W-1:0] sy;
    logic signed [TRIG_W-1:0] cp;
    logic signed [TRIG_W-1:0] sp;
    logic signed [TRIG_W-1:0] fx;
    logic signed [TRIG_W-1:0] fy;
    logic signed [TRIG_W-1:0] ux;
    logic signed [TRIG_W-1:0] uy;
    logic signed [PROD_W-1:0] p0;
    logic signed [PROD_W-1:0] p1;
    logic signed [PROD_W-1:0] p2;
    logic signed [PROD_W-1:0] p3;
    logic signed [PROD_W-1:0] p4;
    logic signed [PROD_W-1:0] p5;
    logic signed [PROD_W-1:0] p6;
    logic signed [PROD_W-1:0] p7;
    logic signed [DOT_W-1:0]  cz;
    logic signed [DOT_W-1:0]  cx;
    logic signed [DOT_W-1:0]  cu;
  } side_t;

  side_t sb_d [DEPTH];
  side_t sb_q [DEPTH];
  logic [DEPTH-1:0] vld_q;

  logic       adv;
  logic [FAR_W-1:0] far_q;
  logic [FOV_W-1:0] fovh_q;
  logic [FOV_W-1:0] fovv_q;

  logic                  out_valid_q;
  logic                  out_vis_q;
  reason_e               out_rsn_q;
  logic [IDX_W-1:0]      out_idx_q;
  reason_e               rsn_d;

  logic signed [SQ_W-1:0]     sq_x, sq_y, sq_z;
  logic [LIMSQ_W-1:0]         lim_sq;
  logic signed [2*TRIG_W-1:0] m_fx, m_fy, m_ux, m_uy;
  logic signed [PROD_W-1:0]   pr0, pr1, pr2, pr3, pr4, pr5, pr6, pr7;
  logic signed [DOT_W-1:0]    near_lim;
  logic signed [TRIG_W-1:0]   cy_w, sy_w, cp_w, sp_w;
  logic [ROOT_W-1:0]          root_w;
  logic signed [ANGLE_W-1:0]  theta, phi, alpha;
  logic signed [LIM_CMP_W-1:0] th_s, ph_s, th_abs, ph_abs, al_s, hlim, vlim;
  logic                        hfail, vfail;
  side_t                       last;

  assign adv           = !out_valid_q || m_axis_tready;
  assign s_axis_tready = adv;
  assign cfg_ready_o   = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      far_q  <= FAR_RESET;
      fovh_q <= FOVH_RESET;
      fovv_q <= FOVV_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_FAR_RANGE: far_q  <= cfg_data_i;
        CFG_FOV_H:     fovh_q <= cfg_data_i[FOV_W-1:0];
        CFG_FOV_V:     fovv_q <= cfg_data_i[FOV_W-1:0];
        default: ;
      endcase
    end
  end

  // arithmetic between stages
  assign sq_x   = $signed(sb_q[0].dx) * $signed(sb_q[0].dx);
  assign sq_y   = $signed(sb_q[0].dy) * $signed(sb_q[0].dy);
  assign sq_z   = $signed(sb_q[0].dz) * $signed(sb_q[0].dz);
  assign lim_sq = sb_q[1].lim * sb_q[1].lim;

  assign m_fx = $signed(sb_q[T_K].cy) * $signed(sb_q[T_K].cp);
  assign m_fy = $signed(sb_q[T_K].sy) * $signed(sb_q[T_K].cp);
  assign m_ux = $signed(sb_q[T_K].cy) * $signed(sb_q[T_K].sp);
  assign m_uy = $signed(sb_q[T_K].sy) * $signed(sb_q[T_K].sp);

  assign pr0 = $signed(sb_q[FX_K].dx) * $signed(sb_q[FX_K].fx);
  assign pr1 = $signed(sb_q[FX_K].dy) * $signed(sb_q[FX_K].fy);
  assign pr2 = $signed(sb_q[FX_K].dz) * $signed(sb_q[FX_K].sp);
  assign pr3 = $signed(sb_q[FX_K].dx) * $signed(sb_q[FX_K].sy);
  assign pr4 = $signed(sb_q[FX_K].dy) * $signed(sb_q[FX_K].cy);
  assign pr5 = $signed(sb_q[FX_K].dx) * $signed(sb_q[FX_K].ux);
  assign pr6 = $signed(sb_q[FX_K].dy) * $signed(sb_q[FX_K].uy);
  assign pr7 = $signed(sb_q[FX_K].dz) * $signed(sb_q[FX_K].cp);

  // near plane: forward <= 2 - radius, in Q30
  assign near_lim = ($signed(DOT_W'(NEAR_UNITS)) - $signed(DOT_W'(sb_q[DOT_K].r))) <<< Q_SHIFT;

  vcsc_rot_cordic u_rot_yaw (
    .clk_i (clk_i),
    .en_i  (adv),
    .ang_i ({sb_q[ROT_K].yaw, {(ANGLE_W-HDG_W){1'b0}}}),
    .cos_o (cy_w),
    .sin_o (sy_w)
  );

  vcsc_rot_cordic u_rot_pitch (
    .clk_i (clk_i),
    .en_i  (adv),
    .ang_i ({sb_q[ROT_K].pitch, {(ANGLE_W-HDG_W){1'b0}}}),
    .cos_o (cp_w),
    .sin_o (sp_w)
  );

  vcsc_isqrt u_isqrt (
    .clk_i  (clk_i),
    .en_i   (adv),
    .n_i    ({sb_q[2].sumsq, {(SQIN_W-SQ_W){1'b0}}}),
    .root_o (root_w)
  );

  vcsc_vec_cordic u_vec_theta (
    .clk_i (clk_i),
    .en_i  (adv),
    .y_i   (VEC_W'($signed(sb_q[DOT_K].cx))),
    .x_i   (VEC_W'($signed(sb_q[DOT_K].cz))),
    .ang_o (theta)
  );

  vcsc_vec_cordic u_vec_phi (
    .clk_i (clk_i),
    .en_i  (adv),
    .y_i   (VEC_W'($signed(sb_q[DOT_K].cu))),
    .x_i   (VEC_W'($signed(sb_q[DOT_K].cz))),
    .ang_o (phi)
  );

  vcsc_vec_cordic u_vec_alpha (
    .clk_i (clk_i),
    .en_i  (adv),
    .y_i   (VEC_W'({sb_q[DOT_K].r, {ALPHA_Y_SHIFT{1'b0}}})),
    .x_i   (VEC_W'({sb_q[DOT_K].span, {ALPHA_X_SHIFT{1'b0}}})),
    .ang_o (alpha)
  );

  always_comb begin
    sb_d[0]       = '0;
    sb_d[0].idx   = s_axis_tdata[OFS_IDX +: IDX_W];
    sb_d[0].r     = s_axis_tdata[OFS_RAD +: RAD_W];
    sb_d[0].wne   = s_axis_tdata[OFS_CWORLD +: WORLD_W] != s_axis_tdata[OFS_OWORLD +: WORLD_W];
    sb_d[0].yaw   = HDG_QUARTER - s_axis_tdata[OFS_HDG +: HDG_W];
    sb_d[0].pitch = s_axis_tdata[OFS_PITCH +: HDG_W];
    sb_d[0].dx    = $signed({s_axis_tdata[OFS_OBJ_X+POS_W-1], s_axis_tdata[OFS_OBJ_X +: POS_W]})
                  - $signed({s_axis_tdata[POS_W-1], s_axis_tdata[0 +: POS_W]});
    sb_d[0].dy    = $signed({s_axis_tdata[OFS_OBJ_Y+POS_W-1], s_axis_tdata[OFS_OBJ_Y +: POS_W]})
                  - $signed({s_axis_tdata[OFS_CAM_Y+POS_W-1], s_axis_tdata[OFS_CAM_Y +: POS_W]});
    sb_d[0].dz    = $signed({s_axis_tdata[OFS_OBJ_Z+POS_W-1], s_axis_tdata[OFS_OBJ_Z +: POS_W]})
                  - $signed({s_axis_tdata[OFS_CAM_Z+POS_W-1], s_axis_tdata[OFS_CAM_Z +: POS_W]});
    for (int k = 1; k < DEPTH; k++) begin
      sb_d[k] = sb_q[k-1];
    end
    sb_d[1].dxx   = SQ_W'(sq_x);
    sb_d[1].dyy   = SQ_W'(sq_y);
    sb_d[1].dzz   = SQ_W'(sq_z);
    sb_d[1].lim   = LIM_W'(far_q) + LIM_W'(sb_q[0].r);
    sb_d[2].sumsq = sb_q[1].dxx + sb_q[1].dyy + sb_q[1].dzz;
    sb_d[2].limsq = lim_sq;
    sb_d[3].far   = sb_q[2].sumsq > SQ_W'(sb_q[2].limsq);
    sb_d[DIST_K].span = root_w;
    sb_d[T_K].cy  = cy_w;
    sb_d[T_K].sy  = sy_w;
    sb_d[T_K].cp  = cp_w;
    sb_d[T_K].sp  = sp_w;
    sb_d[FX_K].fx = m_fx[Q_SHIFT +: TRIG_W];
    sb_d[FX_K].fy = m_fy[Q_SHIFT +: TRIG_W];
    sb_d[FX_K].ux = -$signed(m_ux[Q_SHIFT +: TRIG_W]);
    sb_d[FX_K].uy = -$signed(m_uy[Q_SHIFT +: TRIG_W]);
    sb_d[PR_K].p0 = pr0;
    sb_d[PR_K].p1 = pr1;
    sb_d[PR_K].p2 = pr2;
    sb_d[PR_K].p3 = pr3;
    sb_d[PR_K].p4 = pr4;
    sb_d[PR_K].p5 = pr5;
    sb_d[PR_K].p6 = pr6;
    sb_d[PR_K].p7 = pr7;
    sb_d[DOT_K].cz = $signed(DOT_W'($signed(sb_q[PR_K].p0))) + $signed(DOT_W'($signed(sb_q[PR_K].p1)))
                   + $signed(DOT_W'($signed(sb_q[PR_K].p2)));
    sb_d[DOT_K].cx = $signed(DOT_W'($signed(sb_q[PR_K].p3))) - $signed(DOT_W'($signed(sb_q[PR_K].p4)));
    sb_d[DOT_K].cu = $signed(DOT_W'($signed(sb_q[PR_K].p5))) + $signed(DOT_W'($signed(sb_q[PR_K].p6)))
                   + $signed(DOT_W'($signed(sb_q[PR_K].p7)));
    sb_d[NEAR_K].near = $signed(sb_q[DOT_K].cz) <= near_lim;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sb_q <= sb_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[DEPTH-2:0], s_axis_tvalid};
    end
  end

  // angle tests against half field of view widened by alpha
  assign last   = sb_q[DEPTH-1];
  assign th_s   = LIM_CMP_W'(theta);
  assign ph_s   = LIM_CMP_W'(phi);
  assign al_s   = LIM_CMP_W'(alpha);
  assign th_abs = th_s[LIM_CMP_W-1] ? -th_s : th_s;
  assign ph_abs = ph_s[LIM_CMP_W-1] ? -ph_s : ph_s;
  assign hlim   = $signed(LIM_CMP_W'({fovh_q, {FOV_SHIFT{1'b0}}})) + al_s;
  assign vlim   = $signed(LIM_CMP_W'({fovv_q, {FOV_SHIFT{1'b0}}})) + al_s;
  assign hfail  = th_abs > hlim;
  assign vfail  = ph_abs > vlim;

  always_comb begin
    priority if (last.wne) begin
      rsn_d = RSN_WORLD;
    end else if (last.far) begin
      rsn_d = RSN_FAR;
    end else if (last.near) begin
      rsn_d = RSN_BEHIND;
    end else if (hfail) begin
      rsn_d = RSN_HORIZ;
    end else if (vfail) begin
      rsn_d = RSN_VERT;
    end else begin
      rsn_d = RSN_VISIBLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= vld_q[DEPTH-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_vis_q <= (rsn_d == RSN_VISIBLE);
      out_rsn_q <= rsn_d;
      out_idx_q <= last.idx;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_idx_q, out_rsn_q, out_vis_q};

endmodule

`default_nettype wire

@@ rtl/vcsc_rot_cordic.sv @@
// ---------------------------------------------------------------------------
// vcsc_rot_cordic
// Pipelined rotation CORDIC, one iteration per stage, gives Q30 cos and sin.
// ---------------------------------------------------------------------------
`default_nettype none

module vcsc_rot_cordic import vcsc_pkg::*; (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [ANGLE_W-1:0]       ang_i,
  output logic signed [TRIG_W-1:0] cos_o,
  output logic signed [TRIG_W-1:0] sin_o
);

  localparam int N = CORDIC_STEPS;

  logic signed [ROT_W-1:0] x_d [N+1];
  logic signed [ROT_W-1:0] x_q [N+1];
  logic signed [ROT_W-1:0] y_d [N+1];
  logic signed [ROT_W-1:0] y_q [N+1];
  logic signed [ROT_W-1:0] z_d [N+1];
  logic signed [ROT_W-1:0] z_q [N+1];
  logic                    neg_d [N+1];
  logic                    neg_q [N+1];

  logic [ANGLE_W-1:0] ang_off;
  logic [ANGLE_W-1:0] ang_f;
  logic               flip;

  // fold into [-quarter, quarter) with a half-turn flip
  assign ang_off = ang_i + TURN_QUARTER;
  assign flip    = ang_off[ANGLE_W-1];
  assign ang_f   = flip ? (ang_i ^ TURN_HALF) : ang_i;

  always_comb begin
    x_d[0]   = ROT_W'(CORDIC_GAIN);
    y_d[0]   = '0;
    z_d[0]   = {{(ROT_W-ANGLE_W){ang_f[ANGLE_W-1]}}, ang_f};
    neg_d[0] = flip;
    for (int i = 0; i < N; i++) begin
      if (!z_q[i][ROT_W-1]) begin
        x_d[i+1] = x_q[i] - (y_q[i] >>> i);
        y_d[i+1] = y_q[i] + (x_q[i] >>> i);
        z_d[i+1] = z_q[i] - $signed({{(ROT_W-ANGLE_W){1'b0}}, ATAN_TAB[i]});
      end else begin
        x_d[i+1] = x_q[i] + (y_q[i] >>> i);
        y_d[i+1] = y_q[i] - (x_q[i] >>> i);
        z_d[i+1] = z_q[i] + $signed({{(ROT_W-ANGLE_W){1'b0}}, ATAN_TAB[i]});
      end
      neg_d[i+1] = neg_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q   <= x_d;
      y_q   <= y_d;
      z_q   <= z_d;
      neg_q <= neg_d;
    end
  end

  assign cos_o = TRIG_W'(neg_q[N] ? -x_q[N] : x_q[N]);
  assign sin_o = TRIG_W'(neg_q[N] ? -y_q[N] : y_q[N]);

endmodule

`default_nettype wire

@@ rtl/vcsc_vec_cordic.sv @@
// ---------------------------------------------------------------------------
// vcsc_vec_cordic
// Pipelined vectoring CORDIC giving atan2(y, x) as a signed binary angle.
// ---------------------------------------------------------------------------
`default_nettype none

module vcsc_vec_cordic import vcsc_pkg::*; (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic signed [VEC_W-1:0]   y_i,
  input  logic signed [VEC_W-1:0]   x_i,
  output logic signed [ANGLE_W-1:0] ang_o
);

  localparam int N = CORDIC_STEPS;

  logic signed [VEC_W-1:0] x_d [N+1];
  logic signed [VEC_W-1:0] x_q [N+1];
  logic signed [VEC_W-1:0] y_d [N+1];
  logic signed [VEC_W-1:0] y_q [N+1];
  logic [ANGLE_W-1:0]      z_d [N+1];
  logic [ANGLE_W-1:0]      z_q [N+1];
  logic                    zero_d [N+1];
  logic                    zero_q [N+1];

  always_comb begin
    // left half plane: turn by a half turn first
    x_d[0]    = x_i[VEC_W-1] ? -x_i : x_i;
    y_d[0]    = x_i[VEC_W-1] ? -y_i : y_i;
    z_d[0]    = x_i[VEC_W-1] ? TURN_HALF : '0;
    zero_d[0] = (x_i == '0) && (y_i == '0);
    for (int i = 0; i < N; i++) begin
      if (!y_q[i][VEC_W-1] && (y_q[i] != '0)) begin
        x_d[i+1] = x_q[i] + (y_q[i] >>> i);
        y_d[i+1] = y_q[i] - (x_q[i] >>> i);
        z_d[i+1] = z_q[i] + ATAN_TAB[i];
      end else begin
        x_d[i+1] = x_q[i] - (y_q[i] >>> i);
        y_d[i+1] = y_q[i] + (x_q[i] >>> i);
        z_d[i+1] = z_q[i] - ATAN_TAB[i];
      end
      zero_d[i+1] = zero_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q    <= x_d;
      y_q    <= y_d;
      z_q    <= z_d;
      zero_q <= zero_d;
    end
  end

  assign ang_o = zero_q[N] ? '0 : $signed(z_q[N]);

endmodule

`default_nettype wire

@@ rtl/vcsc_isqrt.sv @@
// ---------------------------------------------------------------------------
// vcsc_isqrt
// Pipelined digit-by-digit integer square root, two root bits per stage.
// ---------------------------------------------------------------------------
`default_nettype none

module vcsc_isqrt import vcsc_pkg::*; (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [SQIN_W-1:0] n_i,
  output logic [ROOT_W-1:0] root_o
);

  logic [SQIN_W-1:0] m_d    [SQ_STAGES];
  logic [SQIN_W-1:0] m_q    [SQ_STAGES];
  logic [REM_W-1:0]  rem_d  [SQ_STAGES];
  logic [REM_W-1:0]  rem_q  [SQ_STAGES];
  logic [ROOT_W-1:0] root_d [SQ_STAGES];
  logic [ROOT_W-1:0] root_q [SQ_STAGES];

  logic [SQIN_W-1:0] m_t;
  logic [REM_W-1:0]  rem_t;
  logic [ROOT_W-1:0] root_t;
  logic [REM_W-1:0]  trial;

  always_comb begin
    m_t    = '0;
    rem_t  = '0;
    root_t = '0;
    trial  = '0;
    for (int s = 0; s < SQ_STAGES; s++) begin
      if (s == 0) begin
        m_t    = n_i;
        rem_t  = '0;
        root_t = '0;
      end else begin
        m_t    = m_q[s-1];
        rem_t  = rem_q[s-1];
        root_t = root_q[s-1];
      end
      for (int j = 0; j < SQ_PER; j++) begin
        rem_t = {rem_t[REM_W-3:0], m_t[SQIN_W-1 -: 2]};
        m_t   = m_t << 2;
        trial = {{(REM_W-ROOT_W-2){1'b0}}, root_t, 2'b01};
        if (rem_t >= trial) begin
          rem_t  = rem_t - trial;
          root_t = {root_t[ROOT_W-2:0], 1'b1};
        end else begin
          root_t = {root_t[ROOT_W-2:0], 1'b0};
        end
      end
      m_d[s]    = m_t;
      rem_d[s]  = rem_t;
      root_d[s] = root_t;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q    <= m_d;
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign root_o = root_q[SQ_STAGES-1];

endmodule

`default_nettype wire

@@ rtl/vcsc_checker.sv @@
// ---------------------------------------------------------------------------
// vcsc_checker
// Port-level checks on the cull unit, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "view_cone_sphere_cull_unit_assert.svh"

module vcsc_checker import vcsc_pkg::*; (
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   s_axis_tvalid,
  input wire logic                   s_axis_tready,
  input wire logic                   m_axis_tvalid,
  input wire logic                   m_axis_tready,
  input wire logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  // a stalled result word holds
  `VCSC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result word changed")

  // visible flag agrees with the reason code
  `VCSC_ASSERT_SAME(a_vis_rsn, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[0] == (m_axis_tdata[3:1] == RSN_VISIBLE), "visible flag and reason disagree")

  `VCSC_ASSERT_SAME(a_rsn_range, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[3:1] <= RSN_VERT, "reason code out of range")

  // with the output register empty the input side must be open
  `VCSC_ASSERT_SAME(a_in_open, clk_i, rst_ni, !m_axis_tvalid, s_axis_tready, "input blocked while output empty")

endmodule

bind view_cone_sphere_cull_unit vcsc_checker u_vcsc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
